// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rfidhex_pkg.sv
// ----------------------------------------------------------------------------
// rfidhex_pkg
// Shared types and constants for the RFID ASCII hex frame parser.
// ----------------------------------------------------------------------------
package rfidhex_pkg;

  localparam int TAG_BYTES_DEF = 5;
  localparam int TAG_W         = 40;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CH_STX = 8'd2;
  localparam logic [7:0] CH_ETX = 8'd3;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] POS_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_STX,
    OP_ETX,
    OP_SKIP,
    OP_DIGIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// File: design/rfid_ascii_hex_frame_parser_core.sv
// ----------------------------------------------------------------------------
// rfid_ascii_hex_frame_parser_core
// Parses an RFID reader's ASCII hex character stream into tag and checksum.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, sustained while results are taken.
// Path: an accepted ETX beat waits in the two-entry token queue, then its
//   tag and check byte are loaded into the result register.
// Reset: clears frame position, pending nibble, stored bytes, queue and
//   result valid; ready is high once the queue is cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfid_ascii_hex_frame_parser_core
  import rfidhex_pkg::*;
#(
  parameter int TAG_BYTES = TAG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  logic [7:0]        char_in,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [TAG_W-1:0]  tag_id,
  output logic [7:0]        check_byte,
  output logic              check_ok
);

  queue_stat_t q_stat;
  logic        push;
  token_t      push_data;
  logic        head_valid;
  token_t      head_data;
  logic        pop;

  rfidhex_front u_front (
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_in    (char_in),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  rfidhex_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .stat       (q_stat)
  );

  rfidhex_back #(
    .TAG_BYTES (TAG_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (head_valid),
    .tok        (head_data),
    .tok_pop    (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .tag_id     (tag_id),
    .check_byte (check_byte),
    .check_ok   (check_ok)
  );

  `ASSERT_ALWAYS(a_queue_stat, !(q_stat.full && q_stat.empty), "queue full and empty")
  `ASSERT_ALWAYS(a_ready_full, char_ready == !q_stat.full, "ready disagrees with queue")
  `ASSERT_NEXT(a_etx_result, pop && head_data.op == OP_ETX, res_valid, "ETX gave no result")
  `ASSERT_NEXT(a_push_fill, push && !pop, !q_stat.empty, "pushed token lost")

endmodule

// File: design/rfidhex_queue.sv
// ----------------------------------------------------------------------------
// rfidhex_queue
// Small FIFO of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module rfidhex_queue
  import rfidhex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  token_t      push_data,
  input  logic        pop,
  output logic        head_valid,
  output token_t      head_data,
  output queue_stat_t stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  token_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  logic do_push;
  logic do_pop;

  assign stat.full   = (count == CW'(QUEUE_DEPTH));
  assign stat.empty  = (count == '0);
  assign head_valid  = !stat.empty;
  assign head_data   = mem[rd_ptr];
  assign do_push     = push && !stat.full;
  assign do_pop      = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/rfidhex_front.sv
// ----------------------------------------------------------------------------
// rfidhex_front
// Accepts received characters and classifies them into parser tokens.
// ----------------------------------------------------------------------------
module rfidhex_front
  import rfidhex_pkg::*;
(
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_in,
  input  queue_stat_t q_stat,
  output logic        push,
  output token_t      push_data
);

  assign char_ready = !q_stat.full;
  assign push       = char_valid && char_ready;

  always_comb begin
    push_data.nib = 4'd0;
    case (char_in)
      CH_STX:        push_data.op = OP_STX;
      CH_ETX:        push_data.op = OP_ETX;
      CH_LF, CH_CR:  push_data.op = OP_SKIP;
      default: begin
        push_data.op = OP_DIGIT;
        // '0'..'9' carry the value in the low nibble; 'A'..'F' sit 9 below it
        if (char_in inside {["0":"9"]}) begin
          push_data.nib = char_in[3:0];
        end else if (char_in inside {["A":"F"]}) begin
          push_data.nib = char_in[3:0] + 4'd9;
        end
      end
    endcase
  end

endmodule

// File: design/rfidhex_back.sv
// ----------------------------------------------------------------------------
// rfidhex_back
// Runs the frame position, packs digit pairs into bytes and builds results.
// ----------------------------------------------------------------------------
module rfidhex_back
  import rfidhex_pkg::*;
#(
  parameter int TAG_BYTES = TAG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  token_t            tok,
  output logic              tok_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [TAG_W-1:0]  tag_id,
  output logic [7:0]        check_byte,
  output logic              check_ok
);

  localparam int FRAME_LEN = TAG_BYTES + 1;

  logic [7:0] pos;
  logic [3:0] high_nib;
  logic [7:0] frame [FRAME_LEN];

  logic [6:0]       idx;
  logic             byte_wr;
  logic [7:0]       pos_adv;
  logic [TAG_W-1:0] tag_acc;
  logic [7:0]       sum_acc;
  logic             out_free;

  // Result register frees up when empty or when its beat is taken.
  assign out_free = !res_valid || res_ready;
  assign tok_pop  = tok_valid && ((tok.op != OP_ETX) || out_free);
  assign idx      = pos[7:1];
  assign byte_wr  = tok_pop && (tok.op == OP_DIGIT) && pos[0] && (idx < 7'(FRAME_LEN));
  assign pos_adv  = (pos == POS_MAX) ? pos : pos + 8'd1;

  always_comb begin
    tag_acc = '0;
    sum_acc = '0;
    for (int i = 0; i < TAG_BYTES; i++) begin
      tag_acc = {tag_acc[TAG_W-9:0], frame[i]};
      sum_acc = sum_acc ^ frame[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      high_nib <= '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        frame[i] <= '0;
      end
    end else if (tok_pop) begin
      if (tok.op == OP_STX) begin
        pos <= '0;
      end else begin
        pos <= pos_adv;
      end
      if (tok.op == OP_DIGIT && !pos[0]) begin
        high_nib <= tok.nib;
      end
      for (int i = 0; i < FRAME_LEN; i++) begin
        if (byte_wr && idx == 7'(i)) begin
          frame[i] <= {high_nib, tok.nib};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tok_pop && tok.op == OP_ETX) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.op == OP_ETX) begin
      tag_id     <= tag_acc;
      check_byte <= frame[TAG_BYTES];
      check_ok   <= (sum_acc == frame[TAG_BYTES]);
    end
  end

endmodule
